// File: rtl/pvc_pkg.sv
// Shared constants and types of the PAL video cycle stepper.
`default_nettype none
package pvc_pkg;
   localparam int MEM_DEPTH = 16384;
   localparam int MEM_AW = $clog2(MEM_DEPTH);
   localparam logic [8:0] LAST_LINE = 9'd311;
   localparam logic [6:0] HBLANK_START = 7'd70;
   localparam logic [6:0] HBLANK_END = 7'd11;
   localparam logic [8:0] VBLANK_END = 9'd9;
   localparam logic [8:0] VSYNC_FIRST = 9'd4;
   localparam logic [8:0] VSYNC_LAST = 9'd6;

   localparam logic [3:0] PH_OUTSIDE = 4'd0;
   localparam logic [3:0] PH_XMATCH = 4'd1;
   localparam logic [3:0] PH_YMATCH = 4'd2;
   localparam logic [3:0] PH_LINE = 4'd3;
   localparam logic [3:0] PH_DELAY1 = 4'd4;
   localparam logic [3:0] PH_DELAY2 = 4'd5;
   localparam logic [3:0] PH_DELAY5 = 4'd8;
   localparam logic [3:0] PH_SCREEN = 4'd9;
   localparam logic [3:0] PH_CHAR = 4'd10;

   localparam logic [1:0] SYNC_NONE = 2'd0;
   localparam logic [1:0] SYNC_HSYNC = 2'd1;
   localparam logic [1:0] SYNC_SHORT = 2'd2;
   localparam logic [1:0] SYNC_LONG = 2'd3;

   localparam logic [1:0] SLOT_BACK = 2'd0;
   localparam logic [1:0] SLOT_BORDER = 2'd1;
   localparam logic [1:0] SLOT_FORE = 2'd2;

   localparam logic [2:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [2:0] CSR_COLUMNS = 3'd2;
   localparam logic [2:0] CSR_ROWS = 3'd3;
   localparam logic [2:0] CSR_TALL = 3'd4;
   localparam logic [2:0] CSR_SCREEN = 3'd5;
   localparam logic [2:0] CSR_COLOUR = 3'd6;
   localparam logic [2:0] CSR_CHAR = 3'd7;

   typedef struct packed {
      logic       mode;
      logic [3:0] border;
      logic [3:0] back;
      logic [3:0] aux;
      logic       normal;
   } item_type;

   typedef struct packed {
      logic [2:0] count;
      logic [3:0] a;
      logic [3:0] b;
      logic [3:0] c;
      logic [3:0] d;
      logic [1:0] sync;
      logic       odd;
      logic       porch;
      logic [8:0] line;
   } result_type;
endpackage
`default_nettype wire

// File: rtl/pvc_vram.sv
// Video byte memory: one write port and two registered read ports.
`default_nettype none
module pvc_vram import pvc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [MEM_AW-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic [MEM_AW-1:0] rd_addr_a,
   input  wire logic [MEM_AW-1:0] rd_addr_b,
   output logic [7:0]             rd_data_a,
   output logic [7:0]             rd_data_b
);
   logic [7:0] mem [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule
`default_nettype wire

// File: rtl/pvc_core.sv
// Raster counters, fetch sequencer and pixel decode of the video stepper.
`default_nettype none
module pvc_core import pvc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [13:0]       csr_wdata,
   input  wire logic              fire,
   input  wire item_type          item,
   input  wire logic [7:0]        rd_data_a,
   input  wire logic [7:0]        rd_data_b,
   output logic [MEM_AW-1:0]      rd_addr_a,
   output logic [MEM_AW-1:0]      rd_addr_b,
   output result_type            result
);
   logic [6:0]  origin_x_ff, columns_ff;
   logic [8:0]  origin_y_ff;
   logic [5:0]  rows_ff;
   logic        tall_ff;
   logic [13:0] screen_base_ff, colour_base_ff, char_base_ff;

   logic [6:0]  hc_ff, hc_in;
   logic [8:0]  vc_ff, vc_in;
   logic [13:0] mc_ff, mc_in, ml_ff, ml_in;
   logic [7:0]  hcc_ff, hcc_in;
   logic [5:0]  vcc_ff, vcc_in;
   logic [3:0]  cd_ff, cd_in;
   logic [3:0]  ph_ff, ph_in;
   logic [7:0]  sc_ff, sc_in;
   logic [3:0]  cn_ff, cn_in;
   logic [2:0]  fg_ff, fg_in;
   logic [1:0]  slot_ff [8];
   logic [1:0]  slot_in [8];

   logic [13:0] char_off, screen_addr, colour_addr, char_addr;

   function automatic logic [3:0] colour_of(input logic [1:0] s, input item_type it,
                                            input logic [2:0] fg);
      logic [3:0] c;
      case (s)
         SLOT_BACK:   c = it.back;
         SLOT_BORDER: c = it.border;
         SLOT_FORE:   c = {1'b0, fg};
         default:     c = it.aux;
      endcase
      return c;
   endfunction

   // Addresses come from settled state, so the read data is ready on the cycle
   // after an item is taken.
   always_comb begin
      char_off = tall_ff ? {2'b00, sc_ff, 4'b0000} : {3'b000, sc_ff, 3'b000};
      screen_addr = screen_base_ff + mc_ff;
      colour_addr = colour_base_ff + mc_ff;
      char_addr = char_base_ff + char_off + {10'd0, cd_ff};
      rd_addr_a = MEM_AW'((ph_ff == PH_CHAR) ? char_addr : screen_addr);
      rd_addr_b = MEM_AW'(colour_addr);
   end

   always_comb begin
      logic       visible, shown;
      logic [3:0] last;
      logic [3:0] px [4];
      logic [2:0] n;
      logic [1:0] sync;
      logic       porch;
      logic       adv, xmatch;
      hc_in = hc_ff; vc_in = vc_ff; mc_in = mc_ff; ml_in = ml_ff;
      hcc_in = hcc_ff; vcc_in = vcc_ff; cd_in = cd_ff; ph_in = ph_ff;
      sc_in = sc_ff; cn_in = cn_ff; fg_in = fg_ff;
      for (int i = 0; i < 8; i++) slot_in[i] = slot_ff[i];
      for (int i = 0; i < 4; i++) px[i] = 4'd0;
      n = 3'd0; sync = SYNC_NONE; porch = 1'b0;
      adv = 1'b0; xmatch = 1'b0;
      last = tall_ff ? 4'd15 : 4'd7;
      visible = 1'b0; shown = 1'b0;
      if (item.mode) begin
         // Memory write: handled by the memory port, counters hold.
      end else if (hc_ff == 7'd0) begin
         for (int i = 0; i < 8; i++) slot_in[i] = SLOT_BORDER;
         if (vc_ff == LAST_LINE) begin
            vc_in = 9'd0; ph_in = PH_OUTSIDE; cd_in = 4'd0;
         end else begin
            vc_in = vc_ff + 9'd1;
         end
         adv = 1'b1; xmatch = 1'b1;
         if (vc_in == 9'd0 || vc_in > VBLANK_END) begin
            sync = SYNC_HSYNC;
         end else if (vc_in >= VSYNC_FIRST && vc_in <= VSYNC_LAST) begin
            sync = SYNC_LONG;
         end else begin
            sync = SYNC_SHORT;
         end
         hc_in = 7'd1;
      end else if (hc_ff == 7'd1) begin
         if (ph_in >= PH_SCREEN) ph_in = PH_LINE;
         if (cd_ff == last) begin
            cd_in = 4'd0;
            ml_in = mc_ff;
            if (vc_ff != 9'd0) begin
               vcc_in = vcc_ff - 6'd1;
               if (vcc_in == 6'd0) ph_in = PH_OUTSIDE;
            end
         end else if (ph_in >= PH_LINE) begin
            cd_in = cd_ff + 4'd1;
         end else if (vc_ff == origin_y_ff) begin
            ph_in = (ph_in == PH_XMATCH) ? PH_DELAY2 : PH_YMATCH;
         end
         if (ph_in == PH_XMATCH) ph_in = PH_OUTSIDE;
         else if (ph_in != PH_OUTSIDE && origin_x_ff == 7'd1) ph_in = PH_DELAY1;
         else if (ph_in == PH_DELAY1) ph_in = PH_DELAY2;
         hcc_in = {1'b0, columns_ff};
         mc_in = ml_in;
         hc_in = 7'd2;
      end else if (hc_ff == 7'd2) begin
         adv = 1'b1;
         if (vc_ff == 9'd0) vcc_in = rows_ff;
         hc_in = 7'd3;
      end else begin
         visible = (vc_ff == 9'd0) || (vc_ff > VBLANK_END);
         shown = hc_ff > HBLANK_END;
         if (!visible) begin
            adv = 1'b1;
            hc_in = (hc_ff == HBLANK_START) ? 7'd0 : hc_ff + 7'd1;
         end else if (hc_ff == HBLANK_START) begin
            n = 3'd2;
            if (ph_ff == PH_SCREEN) begin
               px[0] = colour_of(slot_ff[1], item, fg_ff);
               px[1] = colour_of(slot_ff[2], item, fg_ff);
               ph_in = (hcc_ff != 8'd0) ? PH_CHAR : PH_LINE;
               hcc_in = hcc_ff - 8'd1;
            end else if (ph_ff == PH_CHAR) begin
               px[0] = colour_of(slot_ff[5], item, fg_ff);
               px[1] = colour_of(slot_ff[6], item, fg_ff);
               mc_in = mc_ff + 14'd1;
               ph_in = PH_SCREEN;
            end else begin
               px[0] = item.border; px[1] = item.border;
               if (ph_ff >= PH_DELAY1 && ph_ff <= PH_DELAY5) ph_in = ph_ff + 4'd1;
            end
            porch = 1'b1;
            hc_in = 7'd0;
         end else begin
            if (ph_ff == PH_OUTSIDE) begin
               if (shown) begin
                  n = 3'd4;
                  for (int i = 0; i < 4; i++) px[i] = item.border;
               end
            end else if (ph_ff == PH_YMATCH || ph_ff == PH_LINE) begin
               if (shown) begin
                  n = 3'd4;
                  px[0] = colour_of(slot_ff[5], item, fg_ff);
                  px[1] = colour_of(slot_ff[6], item, fg_ff);
                  px[2] = colour_of(slot_ff[7], item, fg_ff);
                  px[3] = item.border;
               end
               if (hc_ff == origin_x_ff) ph_in = PH_DELAY1;
               for (int i = 0; i < 8; i++) slot_in[i] = SLOT_BORDER;
            end else if (ph_ff >= PH_DELAY1 && ph_ff <= PH_DELAY5) begin
               if (shown) begin
                  n = 3'd4;
                  for (int i = 0; i < 4; i++) px[i] = item.border;
               end else begin
                  for (int i = 1; i < 8; i++) slot_in[i] = SLOT_BORDER;
               end
               ph_in = ph_ff + 4'd1;
            end else if (ph_ff == PH_SCREEN) begin
               sc_in = rd_data_a;
               cn_in = rd_data_b[3:0];
               if (shown) begin
                  n = 3'd4;
                  for (int i = 0; i < 4; i++) px[i] = colour_of(slot_ff[i+1], item, fg_ff);
               end
               ph_in = (hcc_ff != 8'd0) ? PH_CHAR : PH_LINE;
               hcc_in = hcc_ff - 8'd1;
            end else if (ph_ff == PH_CHAR) begin
               if (shown) begin
                  n = 3'd4;
                  px[0] = colour_of(slot_ff[5], item, fg_ff);
                  px[1] = colour_of(slot_ff[6], item, fg_ff);
                  px[2] = colour_of(slot_ff[7], item, fg_ff);
               end
               // Character byte: hires bits, or bit pairs when colour bit 3 is set.
               if (!cn_ff[3]) begin
                  for (int i = 0; i < 8; i++)
                     slot_in[i] = (rd_data_a[7-i] == item.normal) ? SLOT_FORE : SLOT_BACK;
               end else begin
                  for (int i = 0; i < 4; i++) begin
                     slot_in[2*i] = rd_data_a[7-2*i -: 2];
                     slot_in[2*i+1] = rd_data_a[7-2*i -: 2];
                  end
               end
               fg_in = cn_ff[2:0];
               if (shown) px[3] = colour_of(slot_in[0], item, fg_in);
               mc_in = mc_ff + 14'd1;
               ph_in = PH_SCREEN;
            end
            hc_in = hc_ff + 7'd1;
         end
      end
      // Idle advance of the fetch sequencer on counts without pixel work.
      if (adv) begin
         if (ph_in == PH_OUTSIDE) begin
            if (xmatch && hc_ff == origin_x_ff) ph_in = PH_XMATCH;
         end else if (ph_in == PH_YMATCH || ph_in == PH_LINE) begin
            if (hc_ff == origin_x_ff) ph_in = PH_DELAY1;
         end else if (ph_in == PH_SCREEN) begin
            ph_in = (hcc_ff != 8'd0) ? PH_CHAR : PH_LINE;
            hcc_in = hcc_ff - 8'd1;
         end else if (ph_in == PH_CHAR) begin
            mc_in = mc_in + 14'd1;
            ph_in = PH_SCREEN;
         end else if (ph_in >= PH_DELAY1 && ph_in <= PH_DELAY5) begin
            ph_in = ph_in + 4'd1;
         end
      end
      // Long sync lines restart the matrix after the idle advance has run.
      if (sync == SYNC_LONG) begin
         ml_in = 14'd0; mc_in = 14'd0;
      end
      result.count = n;
      result.a = px[0]; result.b = px[1]; result.c = px[2]; result.d = px[3];
      result.sync = sync;
      result.odd = vc_in[0];
      result.porch = porch;
      result.line = vc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= 7'd0; origin_y_ff <= 9'd0; columns_ff <= 7'd22;
         rows_ff <= 6'd23; tall_ff <= 1'b0;
         screen_base_ff <= 14'd0; colour_base_ff <= 14'd0; char_base_ff <= 14'd0;
         hc_ff <= 7'd0; vc_ff <= LAST_LINE; mc_ff <= 14'd0; ml_ff <= 14'd0;
         hcc_ff <= 8'd0; vcc_ff <= 6'd0; cd_ff <= 4'd0; ph_ff <= PH_OUTSIDE;
         sc_ff <= 8'd0; cn_ff <= 4'd0; fg_ff <= 3'd0;
         for (int i = 0; i < 8; i++) slot_ff[i] <= SLOT_BACK;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ORIGIN_X: origin_x_ff <= csr_wdata[6:0];
               CSR_ORIGIN_Y: origin_y_ff <= csr_wdata[8:0];
               CSR_COLUMNS:  columns_ff <= csr_wdata[6:0];
               CSR_ROWS:     rows_ff <= csr_wdata[5:0];
               CSR_TALL:     tall_ff <= csr_wdata[0];
               CSR_SCREEN:   screen_base_ff <= csr_wdata;
               CSR_COLOUR:   colour_base_ff <= csr_wdata;
               CSR_CHAR:     char_base_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (fire) begin
            hc_ff <= hc_in; vc_ff <= vc_in; mc_ff <= mc_in; ml_ff <= ml_in;
            hcc_ff <= hcc_in; vcc_ff <= vcc_in; cd_ff <= cd_in; ph_ff <= ph_in;
            sc_ff <= sc_in; cn_ff <= cn_in; fg_ff <= fg_in;
            for (int i = 0; i < 8; i++) slot_ff[i] <= slot_in[i];
         end
      end
   end
endmodule
`default_nettype wire

// File: rtl/pal_video_chip_cycle_step_top.sv
// Top level of the PAL video cycle stepper: handshakes, item and result registers.
//
//   channel  ports   direction  meaning
//   req      req_*   in         tick or memory write item
//   rsp      rsp_*   out        pixels and line timing of one item
//   csr      csr_*   in         register writes, index 0..7
//
// Each item is handled in two steps: the accept cycle issues the memory reads, then
// a decode cycle uses the registered read data and updates the counters.
// A finished result waits in the output register while the next item is taken.
// Synchronous reset clears counters and settings, not the item, result or memory.
// A held result stalls only the decode cycle of the following item.
`default_nettype none
module pal_video_chip_cycle_step_top import pvc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [13:0] req_mem_addr,
   input  wire logic [7:0]  req_mem_data,
   input  wire logic [3:0]  req_border_colour,
   input  wire logic [3:0]  req_background_colour,
   input  wire logic [3:0]  req_auxiliary_colour,
   input  wire logic        req_normal_video,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_pixel_count,
   output logic [3:0]       rsp_pixel_a,
   output logic [3:0]       rsp_pixel_b,
   output logic [3:0]       rsp_pixel_c,
   output logic [3:0]       rsp_pixel_d,
   output logic [1:0]       rsp_line_sync,
   output logic             rsp_odd_line,
   output logic             rsp_front_porch,
   output logic [8:0]       rsp_raster_line,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [13:0] csr_wdata
);
   logic              busy_ff, busy_in;
   logic              out_valid_ff, out_valid_in;
   item_type          item_ff;
   result_type        out_ff, result;
   logic              accept, fire;
   logic [MEM_AW-1:0] rd_addr_a, rd_addr_b;
   logic [7:0]        rd_data_a, rd_data_b;

   // No item is taken while reset is held.
   assign req_ready = !busy_ff && !reset;
   assign accept = req_valid && req_ready;
   assign fire = busy_ff && (!out_valid_ff || rsp_ready);

   always_comb begin
      busy_in = busy_ff;
      out_valid_in = out_valid_ff;
      if (rsp_ready) out_valid_in = 1'b0;
      if (fire) begin
         busy_in = 1'b0;
         out_valid_in = 1'b1;
      end
      if (accept) busy_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         item_ff <= '{mode: req_mode, border: req_border_colour,
                      back: req_background_colour, aux: req_auxiliary_colour,
                      normal: req_normal_video};
      end
      if (fire) out_ff <= result;
   end

   pvc_vram u_vram (
      .clock     (clock),
      .wr_en     (accept && req_mode),
      .wr_addr   (MEM_AW'(req_mem_addr)),
      .wr_data   (req_mem_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   pvc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (item_ff),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .result    (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_pixel_count = out_ff.count;
   assign rsp_pixel_a = out_ff.a;
   assign rsp_pixel_b = out_ff.b;
   assign rsp_pixel_c = out_ff.c;
   assign rsp_pixel_d = out_ff.d;
   assign rsp_line_sync = out_ff.sync;
   assign rsp_odd_line = out_ff.odd;
   assign rsp_front_porch = out_ff.porch;
   assign rsp_raster_line = out_ff.line;
endmodule
`default_nettype wire
